### hdl/jdb_pkg.sv
// Shared widths, constants and handshake structs of the Jaccard distance block.
package jdb_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned CHUNK_W = 8;
	localparam int unsigned N_CHUNKS = WORD_W / CHUNK_W;
	localparam int unsigned CHUNK_CNT_W = $clog2(N_CHUNKS);
	localparam int unsigned POP_W = $clog2(CHUNK_W + 1);
	localparam int unsigned SUM_W = 23;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned DIST_W = FRAC_W + 1;
	localparam int unsigned STEP_W = $clog2(FRAC_W + 1);
	localparam int unsigned MAX_WORDS_DEF = 65536;
	localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 64'd1;
	localparam logic [DIST_W-1:0] DIST_ONE = DIST_W'(1) << FRAC_W;
	localparam logic [DIST_W-1:0] DIST_ZERO = '0;

	typedef struct packed {
		logic step;
		logic clear;
	} jdb_cnt_ctl_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [SUM_W-1:0] divisor;
	} jdb_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIST_W-1:0] quotient;
	} jdb_div_rsp_t;

endpackage

### hdl/jdb_if.sv
// Valid/ready channel interfaces for word beats and result beats.
interface jdb_word_if;
	logic                       valid;
	logic                       ready;
	logic [jdb_pkg::WORD_W-1:0] word_a;
	logic [jdb_pkg::WORD_W-1:0] word_b;
	logic                       last_word;
	logic                       self_pair;

	modport source (output valid, output word_a, output word_b, output last_word,
		output self_pair, input ready);
	modport sink (input valid, input word_a, input word_b, input last_word,
		input self_pair, output ready);
endinterface

interface jdb_result_if;
	logic                       valid;
	logic                       ready;
	logic [jdb_pkg::DIST_W-1:0] distance;
	logic [jdb_pkg::SUM_W-1:0]  shared_bits;
	logic [jdb_pkg::SUM_W-1:0]  either_bits;

	modport source (output valid, output distance, output shared_bits,
		output either_bits, input ready);
	modport sink (input valid, input distance, input shared_bits,
		input either_bits, output ready);
endinterface

### hdl/jdb_count.sv
// Chunk popcount and saturating intersection/union accumulators.
module jdb_count #(
	parameter int unsigned MAX_WORDS = jdb_pkg::MAX_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  jdb_pkg::jdb_cnt_ctl_t       ctl,
	input  logic [jdb_pkg::CHUNK_W-1:0] chunk_a,
	input  logic [jdb_pkg::CHUNK_W-1:0] chunk_b,
	output logic [jdb_pkg::SUM_W-1:0]   shared_sum,
	output logic [jdb_pkg::SUM_W-1:0]   either_sum
);
	import jdb_pkg::*;

	localparam longint unsigned CAP_RAW = longint'(MAX_WORDS) * longint'(WORD_W);
	localparam longint unsigned CAP = (CAP_RAW > SUM_MAX) ? SUM_MAX : CAP_RAW;
	localparam logic [SUM_W:0] CAP_V = (SUM_W + 1)'(CAP);

	function automatic logic [POP_W-1:0] pop8(input logic [CHUNK_W-1:0] v);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			n = n + POP_W'(v[i]);
		end
		return n;
	endfunction

	logic [SUM_W-1:0] shared_q;
	logic [SUM_W-1:0] either_q;
	logic [SUM_W:0]   shared_add;
	logic [SUM_W:0]   either_add;

	assign shared_add = {1'b0, shared_q} + (SUM_W + 1)'(pop8(chunk_a & chunk_b));
	assign either_add = {1'b0, either_q} + (SUM_W + 1)'(pop8(chunk_a | chunk_b));

	// Clamp per chunk; min(cap, a + x) applied chunk by chunk equals clamping per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shared_q <= '0;
			either_q <= '0;
		end else if (ctl.clear) begin
			shared_q <= '0;
			either_q <= '0;
		end else if (ctl.step) begin
			shared_q <= (shared_add > CAP_V) ? CAP_V[SUM_W-1:0] : shared_add[SUM_W-1:0];
			either_q <= (either_add > CAP_V) ? CAP_V[SUM_W-1:0] : either_add[SUM_W-1:0];
		end
	end

	assign shared_sum = shared_q;
	assign either_sum = either_q;

endmodule

### hdl/jdb_div.sv
// Restoring divider: one quotient bit per cycle of (dividend << 16) / divisor.
module jdb_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jdb_pkg::jdb_div_req_t req,
	output jdb_pkg::jdb_div_rsp_t rsp
);
	import jdb_pkg::*;

	localparam int unsigned REM_W = SUM_W + 1;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [REM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  div_q;
	logic [DIST_W-1:0] quo_q;
	logic [REM_W-1:0]  trial;
	logic              ge;
	logic [REM_W-1:0]  rem_nxt;

	// The first step compares the dividend itself; later steps bring in a zero bit.
	assign trial = (step_q == STEP_W'(FRAC_W)) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
	assign ge = trial >= {1'b0, div_q};
	assign rem_nxt = ge ? (trial - {1'b0, div_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(FRAC_W);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.dividend};
			div_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIST_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

### hdl/jaccard_distance_bitset_top.sv
// Top level of the streaming Jaccard distance unit over 64-bit bitset words.
// Each input beat carries one 64-bit word of each bitset. The block takes one beat at a
// time: the word is counted 8 bits per cycle through one popcount/saturating-add unit, so a
// word that is not the last of its pair keeps ready low while its chunks are counted. On the
// last word the block then looks at the totals in an evaluation state and, unless the pair is a
// self pair or the union is empty, runs a restoring divider that yields one quotient bit per
// cycle. The result lands in an output register; the block reopens for the next beat as
// soon as that register is loaded, while the result still waits downstream. distance is
// 1 - shared/either in unsigned Q1.16 (65536 = 1.0, quotient truncated), 65536 for an
// empty union and 0 for a self pair. Both totals saturate at MAX_WORDS * 64, capped at the
// largest 23-bit value, and clear after each result.
module jaccard_distance_bitset_top #(
	parameter int unsigned MAX_WORDS = jdb_pkg::MAX_WORDS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	jdb_word_if.sink    words,
	jdb_result_if.source result
);
	import jdb_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CNT  = 5'b00010,
		ST_EVAL = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [WORD_W-1:0]      wa_q;
	logic [WORD_W-1:0]      wb_q;
	logic                   last_q;
	logic                   self_q;
	logic [CHUNK_CNT_W-1:0] chunk_q;
	logic [DIST_W-1:0]      dist_q;

	logic                   out_valid_q;
	logic [DIST_W-1:0]      out_dist_q;
	logic [SUM_W-1:0]       out_shared_q;
	logic [SUM_W-1:0]       out_either_q;

	jdb_cnt_ctl_t           cnt_ctl;
	jdb_div_req_t           div_req;
	jdb_div_rsp_t           div_rsp;
	logic [SUM_W-1:0]       shared_sum;
	logic [SUM_W-1:0]       either_sum;

	logic                   in_beat;
	logic                   out_beat;
	logic                   out_load;
	logic                   last_chunk;
	logic                   need_div;

	assign in_beat = words.valid && words.ready;
	assign out_beat = result.valid && result.ready;
	// Load the result register when it is empty or being drained this cycle.
	assign out_load = (state_q == ST_HOLD) && (!out_valid_q || result.ready);
	assign last_chunk = chunk_q == CHUNK_CNT_W'(N_CHUNKS - 1);
	assign need_div = !self_q && (either_sum != '0);

	assign words.ready = state_q == ST_IDLE;

	// Shared popcount and accumulate unit; fed the low chunk of the shifting word registers.
	assign cnt_ctl.step = state_q == ST_CNT;
	assign cnt_ctl.clear = out_load;

	jdb_count #(
		.MAX_WORDS(MAX_WORDS)
	) u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (cnt_ctl),
		.chunk_a   (wa_q[CHUNK_W-1:0]),
		.chunk_b   (wb_q[CHUNK_W-1:0]),
		.shared_sum(shared_sum),
		.either_sum(either_sum)
	);

	// Shared never exceeds either (AND is within OR, and clamping keeps the order);
	// guard the difference anyway.
	assign div_req.start = (state_q == ST_EVAL) && need_div;
	assign div_req.dividend = (either_sum >= shared_sum) ? (either_sum - shared_sum) : '0;
	assign div_req.divisor = either_sum;

	jdb_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Sequencer: take a beat, count it chunk by chunk, then on a last word resolve the
	// distance and park it until the result register can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_CNT;
						chunk_q <= '0;
					end
				end
				ST_CNT: begin
					chunk_q <= chunk_q + CHUNK_CNT_W'(1);
					if (last_chunk) begin
						state_q <= last_q ? ST_EVAL : ST_IDLE;
					end
				end
				ST_EVAL: begin
					state_q <= need_div ? ST_DIV : ST_HOLD;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Word registers: capture on the beat, advance one chunk per counting cycle.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			wa_q <= words.word_a;
			wb_q <= words.word_b;
			last_q <= words.last_word;
			self_q <= words.self_pair;
		end else if (state_q == ST_CNT) begin
			wa_q <= wa_q >> CHUNK_W;
			wb_q <= wb_q >> CHUNK_W;
		end
	end

	// Distance: fixed answers for self pair and empty union, otherwise the quotient.
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			dist_q <= self_q ? DIST_ZERO : DIST_ONE;
		end else if ((state_q == ST_DIV) && div_rsp.done) begin
			dist_q <= div_rsp.quotient;
		end
	end

	// Result register: hold until taken downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_beat) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dist_q <= dist_q;
			out_shared_q <= shared_sum;
			out_either_q <= either_sum;
		end
	end

	assign result.valid = out_valid_q;
	assign result.distance = out_dist_q;
	assign result.shared_bits = out_shared_q;
	assign result.either_bits = out_either_q;

endmodule

### hdl/jdb_checker.sv
// Port-level checker for the Jaccard distance block, bound to the top level.
module jdb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       words_valid,
	input logic                       words_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [jdb_pkg::DIST_W-1:0] distance,
	input logic [jdb_pkg::SUM_W-1:0]  shared_bits,
	input logic [jdb_pkg::SUM_W-1:0]  either_bits
);
	import jdb_pkg::*;

	// A stalled result beat holds its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(distance)
			&& $stable(shared_bits) && $stable(either_bits))
		else $error("result beat changed while stalled");

	// One word at a time: ready drops after every accepted beat.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		words_valid && words_ready |=> !words_ready)
		else $error("second word beat taken while counting");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> distance <= DIST_ONE)
		else $error("distance above 1.0");

	a_shared_le: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> shared_bits <= either_bits)
		else $error("intersection count exceeds union count");

	// Identical nonzero totals mean a distance of zero.
	a_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (shared_bits == either_bits) && (either_bits != '0)
			|-> distance == DIST_ZERO)
		else $error("equal totals with nonzero distance");

endmodule

bind jaccard_distance_bitset_top jdb_checker u_jdb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.words_valid(words.valid),
	.words_ready(words.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.distance   (result.distance),
	.shared_bits(result.shared_bits),
	.either_bits(result.either_bits)
);

### test/testbench.sv
// Self-checking testbench for the streaming Jaccard distance unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import jdb_pkg::*;

	// Run the block at its default word cap; pairs stay a handful of beats long.
	localparam int unsigned MAX_WORDS_TB = MAX_WORDS_DEF;
	localparam int unsigned LONG_PAIR = 8;
	localparam longint unsigned COUNT_CAP =
		(longint'(MAX_WORDS_TB) * 64 > SUM_MAX) ? SUM_MAX : longint'(MAX_WORDS_TB) * 64;
	localparam int unsigned CLK_PERIOD = 20;
	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned RX_HOLD_CYCLES = 400;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned END_DRAIN_CYCLES = 64;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic [WORD_W-1:0] word_a;
		logic [WORD_W-1:0] word_b;
		logic              last_word;
		logic              self_pair;
	} word_beat_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [SUM_W-1:0]  shared_bits;
		logic [SUM_W-1:0]  either_bits;
	} distance_result_t;

	typedef enum int unsigned {
		SHAPE_UNIFORM,
		SHAPE_FULL,
		SHAPE_EMPTY,
		SHAPE_SPARSE,
		SHAPE_DENSE
	} word_shape_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Drive every channel input from plain variables so they are known from time zero.
	logic       offer_valid = 1'b0;
	word_beat_t offered = '0;
	logic       rx_ready = 1'b0;

	jdb_word_if   words_if ();
	jdb_result_if result_if ();

	assign words_if.valid     = offer_valid;
	assign words_if.word_a    = offered.word_a;
	assign words_if.word_b    = offered.word_b;
	assign words_if.last_word = offered.last_word;
	assign words_if.self_pair = offered.self_pair;
	assign result_if.ready    = rx_ready;

	jaccard_distance_bitset_top #(
		.MAX_WORDS(MAX_WORDS_TB)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.words (words_if),
		.result(result_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	word_beat_t       pending_words[$];
	distance_result_t distances_due[$];

	// Running totals of the pair in flight, as the block should hold them.
	logic [SUM_W-1:0] shared_acc = '0;
	logic [SUM_W-1:0] either_acc = '0;

	int unsigned mismatches = 0;
	int unsigned send_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned rx_hold_left = 0;
	int unsigned rx_hold_asked = 0;
	int unsigned rx_hold_taken = 0;
	int unsigned idle_cycles = 0;
	logic        no_idle = 1'b0;

	function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, int unsigned add);
		longint unsigned total;
		total = longint'(acc) + add;
		return (total > COUNT_CAP) ? SUM_W'(COUNT_CAP) : SUM_W'(total);
	endfunction

	// Fold one accepted beat into the totals; on a last word, owe a result and clear.
	function automatic void tally_word(word_beat_t beat);
		distance_result_t res;
		longint unsigned  span;
		shared_acc = sat_sum(shared_acc, $countones(beat.word_a & beat.word_b));
		either_acc = sat_sum(either_acc, $countones(beat.word_a | beat.word_b));
		if (beat.last_word) begin
			if (beat.self_pair) begin
				res.distance = DIST_ZERO;
			end else if (either_acc == '0) begin
				res.distance = DIST_ONE;
			end else begin
				span = (either_acc >= shared_acc) ? longint'(either_acc - shared_acc) : 0;
				res.distance = DIST_W'((span << FRAC_W) / longint'(either_acc));
			end
			res.shared_bits = shared_acc;
			res.either_bits = either_acc;
			distances_due = {distances_due, res};
			shared_acc = '0;
			either_acc = '0;
		end
	endfunction

	function automatic void note_mismatch(string field, longint unsigned want,
		longint unsigned got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned draw_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 3);
		else if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_W-1:0] shaped_word(word_shape_e shape);
		logic [WORD_W-1:0] w;
		case (shape)
			SHAPE_FULL: begin
				w = '1;
			end
			SHAPE_EMPTY: begin
				w = '0;
			end
			SHAPE_SPARSE: begin
				w = '0;
				repeat ($urandom_range(1, 4)) w[$urandom_range(0, WORD_W - 1)] = 1'b1;
			end
			SHAPE_DENSE: begin
				w = '1;
				repeat ($urandom_range(1, 4)) w[$urandom_range(0, WORD_W - 1)] = 1'b0;
			end
			default: begin
				w = {$urandom, $urandom};
			end
		endcase
		return w;
	endfunction

	function automatic void queue_word(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
		logic last, logic self);
		word_beat_t beat;
		beat.word_a = a;
		beat.word_b = b;
		beat.last_word = last;
		beat.self_pair = self;
		pending_words = {pending_words, beat};
	endfunction

	// Queue one whole pair with random content; return how many beats it takes.
	function automatic int unsigned queue_random_pair();
		int unsigned       n_words;
		int unsigned       roll;
		int unsigned       link;
		word_shape_e       shape_a;
		word_shape_e       shape_b;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              last;
		logic              self;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			n_words = $urandom_range(1, 3);
		else if (roll < 92)
			n_words = $urandom_range(4, LONG_PAIR);
		else
			n_words = $urandom_range(LONG_PAIR + 1, LONG_PAIR + 4);
		shape_a = word_shape_e'($urandom_range(SHAPE_UNIFORM, SHAPE_DENSE));
		shape_b = word_shape_e'($urandom_range(SHAPE_UNIFORM, SHAPE_DENSE));
		link = $urandom_range(0, 99);
		for (int unsigned k = 0; k < n_words; k++) begin
			a = shaped_word(shape_a);
			if (link < 15)
				b = a;
			else if (link < 25)
				b = ~a;
			else
				b = shaped_word(shape_b);
			last = (k == n_words - 1);
			// The flag only counts on the last word; sprinkle it elsewhere as noise.
			self = last ? ($urandom_range(0, 99) < 12) : ($urandom_range(0, 99) < 20);
			queue_word(a, b, last, self);
		end
		return n_words;
	endfunction

	task automatic queue_random_beats(int unsigned n_beats);
		int unsigned made;
		made = 0;
		while (made < n_beats)
			made += queue_random_pair();
	endtask

	// Hold the sender until every queued beat is in and every owed result is out.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || offer_valid || distances_due.size() != 0);
	endtask

	// Word driver: hold a beat until it is taken, then idle for the drawn gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offer_valid <= 1'b0;
			offered <= '0;
			send_gap = 0;
			shared_acc = '0;
			either_acc = '0;
		end else begin
			if (offer_valid && words_if.ready)
				tally_word(offered);
			if (!offer_valid || words_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					offer_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					offered <= pending_words.pop_front();
					offer_valid <= 1'b1;
					send_gap = (!no_idle && $urandom_range(0, 99) < 35) ? draw_gap() : 0;
				end else begin
					offer_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each taken beat against the oldest owed result, then pick
	// the next cycle's ready from a long hold-off, a random stall, or open.
	always @(posedge clk or negedge arst_n) begin
		distance_result_t want;
		if (!arst_n) begin
			rx_ready <= 1'b0;
			rx_gap = 0;
			rx_hold_left = 0;
		end else begin
			if (result_if.valid && rx_ready) begin
				if (distances_due.size() == 0) begin
					note_mismatch("distance (no result owed)", 0, result_if.distance);
				end else begin
					want = distances_due.pop_front();
					if (result_if.distance !== want.distance)
						note_mismatch("distance", want.distance, result_if.distance);
					if (result_if.shared_bits !== want.shared_bits)
						note_mismatch("shared_bits", want.shared_bits, result_if.shared_bits);
					if (result_if.either_bits !== want.either_bits)
						note_mismatch("either_bits", want.either_bits, result_if.either_bits);
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				rx_ready <= 1'b0;
			end else if (rx_hold_taken != rx_hold_asked) begin
				rx_hold_taken++;
				rx_hold_left = RX_HOLD_CYCLES - 1;
				rx_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rx_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 20) begin
				rx_gap = draw_gap() - 1;
				rx_ready <= 1'b0;
			end else begin
				rx_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((offer_valid && words_if.ready) || (result_if.valid && rx_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty union, self pairs, full words, truncation, ignored flag, long pair.
		queue_word('0, '0, 1'b1, 1'b0);
		queue_word('0, '0, 1'b1, 1'b1);
		queue_word('1, '1, 1'b1, 1'b0);
		queue_word('1, '0, 1'b1, 1'b0);
		queue_word('1, '1, 1'b1, 1'b1);
		queue_word(64'h5555_5555_5555_5555, '1, 1'b0, 1'b1);
		queue_word(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b1, 1'b0);
		queue_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, 1'b0);
		queue_word(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001, 1'b1, 1'b0);
		queue_word(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001, 1'b1, 1'b0);
		queue_word(64'h0000_0000_0000_0003, 64'h0000_0000_0000_0006, 1'b1, 1'b0);
		for (int unsigned k = 0; k <= LONG_PAIR; k++)
			queue_word('1, '1, k == LONG_PAIR, 1'b0);
		queue_word(64'hFFFF_0000_FFFF_0000, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b0);
		wait_drained();

		queue_random_beats(350);
		wait_drained();

		// Hold the receiver off while the sender keeps offering, so the block backs up.
		@(negedge clk);
		rx_hold_asked++;
		queue_random_beats(60);
		wait_drained();

		// Run a stretch with no idling on either side.
		@(negedge clk);
		no_idle = 1'b1;
		queue_random_beats(250);
		wait_drained();
		@(negedge clk);
		no_idle = 1'b0;

		queue_random_beats(470);
		wait_drained();

		repeat (END_DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && distances_due.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
